FILE: sv/hms_pkg.sv
// ----------------------------------------------------------------------------
// hms_pkg
// Shared types, constants and digit helpers for the time-of-day clock.
// ----------------------------------------------------------------------------
package hms_pkg;

    localparam int PERIOD_W   = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int HOUR_W     = 5;
    localparam int MIN_W      = 6;
    localparam int SEC_W      = 6;
    localparam int STROBE_W   = 8;
    localparam int CODE_W     = 4;
    localparam int DIGIT_W    = 3;

    // Snapshot queue between the tick front end and the digit scanner.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [PERIOD_W-1:0] PERIOD_NORMAL_RST  = 10'd1000;
    localparam logic [PERIOD_W-1:0] PERIOD_FAST_RST    = 10'd100;
    localparam logic [PERIOD_W-1:0] PERIOD_FASTER_RST  = 10'd10;
    localparam logic [PERIOD_W-1:0] PERIOD_FASTEST_RST = 10'd1;

    localparam logic [HOUR_W-1:0] HOUR_MAX = 5'd23;
    localparam logic [MIN_W-1:0]  MIN_MAX  = 6'd59;
    localparam logic [SEC_W-1:0]  SEC_MAX  = 6'd59;

    localparam logic [CODE_W-1:0] CODE_BLANK = 4'hE;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_NORMAL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_FAST    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_FASTER  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_FASTEST = 3'd3;

    // Position of each word within one scan.
    localparam logic [DIGIT_W-1:0] DIG_HOUR_TENS = 3'd0;
    localparam logic [DIGIT_W-1:0] DIG_HOUR_UNIT = 3'd1;
    localparam logic [DIGIT_W-1:0] DIG_MIN_TENS  = 3'd2;
    localparam logic [DIGIT_W-1:0] DIG_MIN_UNIT  = 3'd3;
    localparam logic [DIGIT_W-1:0] DIG_SEC_TENS  = 3'd4;
    localparam logic [DIGIT_W-1:0] DIG_SEC_UNIT  = 3'd5;
    localparam logic [DIGIT_W-1:0] DIG_BLANK     = 3'd6;
    localparam logic [DIGIT_W-1:0] DIG_LAST      = 3'd7;

    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
    } hms_time_t;

    typedef struct packed {
        logic [STROBE_W-1:0] strobe;
        logic [CODE_W-1:0]   code;
    } hms_digit_t;

    // Tens digit of a value below 64 by a compare chain.
    function automatic logic [CODE_W-1:0] tens_of(input logic [5:0] v);
        logic [CODE_W-1:0] t;
        if (v >= 6'd60)      t = 4'd6;
        else if (v >= 6'd50) t = 4'd5;
        else if (v >= 6'd40) t = 4'd4;
        else if (v >= 6'd30) t = 4'd3;
        else if (v >= 6'd20) t = 4'd2;
        else if (v >= 6'd10) t = 4'd1;
        else                 t = 4'd0;
        return t;
    endfunction

    function automatic logic [CODE_W-1:0] units_of(input logic [5:0] v);
        logic [5:0] tens_x10;
        logic [5:0] rem;
        tens_x10 = {2'b00, tens_of(v)} * 6'd10;
        rem = v - tens_x10;
        return rem[CODE_W-1:0];
    endfunction

    function automatic hms_digit_t digit_of(input hms_time_t t,
                                            input logic [DIGIT_W-1:0] idx);
        hms_digit_t d;
        logic [5:0] hour6;
        hour6 = {1'b0, t.hour};
        unique case (idx)
            DIG_HOUR_TENS: d = '{strobe: 8'h02, code: tens_of(hour6)};
            DIG_HOUR_UNIT: d = '{strobe: 8'h04, code: units_of(hour6)};
            DIG_MIN_TENS:  d = '{strobe: 8'h08, code: tens_of(t.minute)};
            DIG_MIN_UNIT:  d = '{strobe: 8'h10, code: units_of(t.minute)};
            DIG_SEC_TENS:  d = '{strobe: 8'h20, code: tens_of(t.second)};
            DIG_SEC_UNIT:  d = '{strobe: 8'h40, code: units_of(t.second)};
            DIG_BLANK:     d = '{strobe: 8'h01, code: CODE_BLANK};
            DIG_LAST:      d = '{strobe: 8'h80, code: CODE_BLANK | {3'b000, t.second[0]}};
            default:       d = '{strobe: 8'h00, code: 4'h0};
        endcase
        return d;
    endfunction

endpackage

FILE: sv/hms_front.sv
// ----------------------------------------------------------------------------
// hms_front
// Takes tick words, runs the prescaler and the time counters, and posts a
// time snapshot to the scan queue on every tick that steps the clock.
// ----------------------------------------------------------------------------
module hms_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                tick_accept,
    input  logic                                button_one,
    input  logic                                button_two,
    input  logic                                button_three,
    input  logic                                cfg_write,
    input  logic [hms_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hms_pkg::PERIOD_W-1:0]        cfg_data,
    output logic                                snap_push,
    output hms_pkg::hms_time_t                  snap
);

    logic [hms_pkg::PERIOD_W-1:0] period_normal_reg;
    logic [hms_pkg::PERIOD_W-1:0] period_fast_reg;
    logic [hms_pkg::PERIOD_W-1:0] period_faster_reg;
    logic [hms_pkg::PERIOD_W-1:0] period_fastest_reg;
    logic [hms_pkg::PERIOD_W-1:0] tick_count_reg;
    logic [hms_pkg::PERIOD_W-1:0] tick_count_next;
    hms_pkg::hms_time_t           time_reg;
    hms_pkg::hms_time_t           time_next;
    hms_pkg::hms_time_t           stepped;
    logic [hms_pkg::PERIOD_W-1:0] period;
    logic [hms_pkg::PERIOD_W-1:0] tick_inc;
    logic                         any_button;
    logic                         step;
    logic                         min_carry;

    always_comb
    begin
        if (button_three)
            period = period_fastest_reg;
        else if (button_two)
            period = period_faster_reg;
        else if (button_one)
            period = period_fast_reg;
        else
            period = period_normal_reg;
    end

    assign any_button = button_one | button_two | button_three;
    assign tick_inc   = tick_count_reg + 10'd1;
    assign step       = tick_inc >= period;

    // A held button moves minutes directly; otherwise seconds carry upward.
    always_comb
    begin
        stepped   = time_reg;
        min_carry = 1'b0;
        if (any_button)
        begin
            min_carry = 1'b1;
        end
        else if (time_reg.second < hms_pkg::SEC_MAX)
        begin
            stepped.second = time_reg.second + 6'd1;
        end
        else
        begin
            stepped.second = '0;
            min_carry      = 1'b1;
        end
        if (min_carry)
        begin
            if (time_reg.minute < hms_pkg::MIN_MAX)
            begin
                stepped.minute = time_reg.minute + 6'd1;
            end
            else
            begin
                stepped.minute = '0;
                if (time_reg.hour < hms_pkg::HOUR_MAX)
                    stepped.hour = time_reg.hour + 5'd1;
                else
                    stepped.hour = '0;
            end
        end
    end

    always_comb
    begin
        tick_count_next = tick_count_reg;
        time_next       = time_reg;
        if (tick_accept)
        begin
            if (step)
            begin
                tick_count_next = '0;
                time_next       = stepped;
            end
            else
            begin
                tick_count_next = tick_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            time_reg       <= '0;
        end
        else
        begin
            tick_count_reg <= tick_count_next;
            time_reg       <= time_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_normal_reg  <= hms_pkg::PERIOD_NORMAL_RST;
            period_fast_reg    <= hms_pkg::PERIOD_FAST_RST;
            period_faster_reg  <= hms_pkg::PERIOD_FASTER_RST;
            period_fastest_reg <= hms_pkg::PERIOD_FASTEST_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                hms_pkg::REG_PERIOD_NORMAL:  period_normal_reg  <= cfg_data;
                hms_pkg::REG_PERIOD_FAST:    period_fast_reg    <= cfg_data;
                hms_pkg::REG_PERIOD_FASTER:  period_faster_reg  <= cfg_data;
                hms_pkg::REG_PERIOD_FASTEST: period_fastest_reg <= cfg_data;
                default:                     ;
            endcase
        end
    end

    assign snap_push = tick_accept & step;
    assign snap      = stepped;

    // The prescaler is cleared whenever a step is posted.
    a_step_clears: assert property (@(posedge clk) disable iff (!rst_n)
        snap_push |=> tick_count_reg == '0)
        else $error("prescaler not cleared after a step");

endmodule

FILE: sv/hms_queue.sv
// ----------------------------------------------------------------------------
// hms_queue
// Short queue of time snapshots between the front end and the scanner.
// ----------------------------------------------------------------------------
module hms_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  hms_pkg::hms_time_t push_data,
    input  logic               pop,
    output logic               full,
    output logic               head_valid,
    output hms_pkg::hms_time_t head
);

    hms_pkg::hms_time_t              entry_reg [hms_pkg::QUEUE_DEPTH];
    logic [hms_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [hms_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [hms_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [hms_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [hms_pkg::QCNT_W-1:0]      count_reg;
    logic [hms_pkg::QCNT_W-1:0]      count_next;
    logic                            do_push;
    logic                            do_pop;

    localparam logic [hms_pkg::QPTR_W-1:0] PTR_LAST = hms_pkg::QPTR_W'(hms_pkg::QUEUE_DEPTH - 1);
    localparam logic [hms_pkg::QCNT_W-1:0] CNT_FULL = hms_pkg::QCNT_W'(hms_pkg::QUEUE_DEPTH);

    assign full       = count_reg == CNT_FULL;
    assign head_valid = count_reg != '0;
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push & ~full;
    assign do_pop     = pop & head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("snapshot queue count overflow");

    a_no_lost_push: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("snapshot pushed into a full queue");

endmodule

FILE: sv/hms_scan.sv
// ----------------------------------------------------------------------------
// hms_scan
// Walks the eight display digits of the snapshot at the queue head and
// holds each digit word in an output register until it is taken.
// ----------------------------------------------------------------------------
module hms_scan
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           head_valid,
    input  hms_pkg::hms_time_t             head,
    output logic                           head_pop,
    input  logic                           pop,
    output logic                           empty,
    output logic [hms_pkg::STROBE_W-1:0]   digit_strobe,
    output logic [hms_pkg::CODE_W-1:0]     digit_code,
    output logic                           last_digit
);

    logic [hms_pkg::DIGIT_W-1:0]  idx_reg;
    logic [hms_pkg::DIGIT_W-1:0]  idx_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    hms_pkg::hms_digit_t          out_reg;
    hms_pkg::hms_digit_t          out_next;
    logic                         last_reg;
    logic                         last_next;
    logic                         load;

    // The output register refills in the same cycle its word is taken.
    assign load     = head_valid & (~out_valid_reg | pop);
    assign head_pop = load & (idx_reg == hms_pkg::DIG_LAST);

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        last_next      = last_reg;
        if (load)
        begin
            idx_next       = idx_reg + 3'd1;
            out_valid_next = 1'b1;
            out_next       = hms_pkg::digit_of(head, idx_reg);
            last_next      = idx_reg == hms_pkg::DIG_LAST;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        last_reg <= last_next;
    end

    assign empty        = ~out_valid_reg;
    assign digit_strobe = out_reg.strobe;
    assign digit_code   = out_reg.code;
    assign last_digit   = last_reg;

    a_strobe_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $onehot(out_reg.strobe))
        else $error("digit strobe is not one-hot");

    a_last_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg) |-> out_reg.strobe == 8'h80)
        else $error("last digit word carries the wrong strobe");

endmodule

FILE: sv/hms_clock_with_digit_scan_core.sv
// ----------------------------------------------------------------------------
// hms_clock_with_digit_scan_core
// 24-hour time-of-day clock driven by millisecond ticks, with an
// eight-digit display scan emitted on every time step.
//
//   channel   direction  handshake            word
//   -------   ---------  -------------------  ------------------------------
//   tick      in         push / full          button_one/two/three
//   digit     out        empty / pop          digit_strobe, digit_code, last
//   cfg       in         cfg_valid/cfg_ready  cfg_index, cfg_data (periods)
//
// A tick is taken whenever the two-entry snapshot queue has room, also
// a tick that does not step the clock and so yields no digit word.
// A stepping tick yields eight digit words, delivered one per cycle by the
// scanner while the consumer keeps popping.
// Reset clears the prescaler, the time and the queue, and loads the
// period registers with their defaults; no clearing pass is needed.
// A stalled digit consumer fills the queue and then raises full.
// ----------------------------------------------------------------------------
module hms_clock_with_digit_scan_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic                               button_one,
    input  logic                               button_two,
    input  logic                               button_three,
    output logic                               empty,
    input  logic                               pop,
    output logic [hms_pkg::STROBE_W-1:0]       digit_strobe,
    output logic [hms_pkg::CODE_W-1:0]         digit_code,
    output logic                               last_digit,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [hms_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hms_pkg::PERIOD_W-1:0]       cfg_data
);

    logic               queue_full;
    logic               tick_accept;
    logic               snap_push;
    hms_pkg::hms_time_t snap;
    logic               head_valid;
    hms_pkg::hms_time_t head;
    logic               head_pop;

    assign full        = queue_full;
    assign tick_accept = push & ~queue_full;
    assign cfg_ready   = 1'b1;

    hms_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_accept  (tick_accept),
        .button_one   (button_one),
        .button_two   (button_two),
        .button_three (button_three),
        .cfg_write    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .snap_push    (snap_push),
        .snap         (snap)
    );

    hms_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (snap_push),
        .push_data  (snap),
        .pop        (head_pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head       (head)
    );

    hms_scan u_scan
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .head_pop     (head_pop),
        .pop          (pop),
        .empty        (empty),
        .digit_strobe (digit_strobe),
        .digit_code   (digit_code),
        .last_digit   (last_digit)
    );

endmodule

FILE: tb/tb_hms_clock_with_digit_scan_core.sv
// ----------------------------------------------------------------------------
// tb_hms_clock_with_digit_scan_core
// Self-checking bench for the time-of-day clock. Millisecond ticks with
// random button levels go in through the push/full side. A local copy of
// the prescaler and time registers predicts every eight-word digit scan.
// Each word popped from the block is checked against the oldest prediction.
// The period registers are reprogrammed between phases while the block idles.
// ----------------------------------------------------------------------------
module tb_hms_clock_with_digit_scan_core;

    localparam int          CLK_HALF        = 5;
    localparam int          RESET_CYCLES    = 12;
    localparam int          SETTLE_CYCLES   = 20;
    localparam int          HOLD_OFF_CYCLES = 400;
    localparam int          CYCLE_LIMIT     = 1000000;
    localparam int          RANDOM_PHASES   = 5;
    localparam int          TICKS_PER_PHASE = 56;
    localparam logic [3:0]  BLANK_CODE      = 4'hE;
    localparam logic [9:0]  NORMAL_DEFAULT  = 10'd1000;
    localparam logic [9:0]  FAST_DEFAULT    = 10'd100;
    localparam logic [9:0]  FASTER_DEFAULT  = 10'd10;
    localparam logic [9:0]  FASTEST_DEFAULT = 10'd1;

    typedef struct packed {
        logic [7:0] strobe;
        logic [3:0] code;
        logic       last;
    } scan_word_t;

    logic                            clk;
    logic                            rst_n;
    logic                            push;
    logic                            full;
    logic                            button_one;
    logic                            button_two;
    logic                            button_three;
    logic                            empty;
    logic                            pop;
    logic [hms_pkg::STROBE_W-1:0]    digit_strobe;
    logic [hms_pkg::CODE_W-1:0]      digit_code;
    logic                            last_digit;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [hms_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [hms_pkg::PERIOD_W-1:0]    cfg_data;

    // Local copy of the clock state and the period registers.
    logic [9:0] period_normal;
    logic [9:0] period_fast;
    logic [9:0] period_faster;
    logic [9:0] period_fastest;
    logic [9:0] tick_count;
    logic [5:0] second_count;
    logic [5:0] minute_count;
    logic [4:0] hour_count;

    scan_word_t pending_digits[$];
    int         mismatches = 0;
    int         cycle_count = 0;
    bit         sender_idles = 1'b0;
    int         burst_left = 0;

    // Receiver pattern state, owned by the pop process; the tests raise hold_requests.
    int hold_requests;
    int hold_seen = 0;
    int stall_left = 0;
    int mode_left = 0;
    int pop_mode = 0;

    hms_clock_with_digit_scan_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .button_one   (button_one),
        .button_two   (button_two),
        .button_three (button_three),
        .empty        (empty),
        .pop          (pop),
        .digit_strobe (digit_strobe),
        .digit_code   (digit_code),
        .last_digit   (last_digit),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Clock model
    // ------------------------------------------------------------------
    task automatic reset_clock_model();
        period_normal  = NORMAL_DEFAULT;
        period_fast    = FAST_DEFAULT;
        period_faster  = FASTER_DEFAULT;
        period_fastest = FASTEST_DEFAULT;
        tick_count     = '0;
        second_count   = '0;
        minute_count   = '0;
        hour_count     = '0;
    endtask

    task automatic step_minute();
        if (minute_count < 6'd59)
            minute_count = minute_count + 6'd1;
        else
        begin
            minute_count = '0;
            if (hour_count < 5'd23)
                hour_count = hour_count + 5'd1;
            else
                hour_count = '0;
        end
    endtask

    task automatic step_second();
        if (second_count < 6'd59)
            second_count = second_count + 6'd1;
        else
        begin
            second_count = '0;
            step_minute();
        end
    endtask

    task automatic queue_digit(input logic [7:0] strobe, input logic [3:0] code,
                               input logic last);
        scan_word_t w;
        w.strobe = strobe;
        w.code   = code;
        w.last   = last;
        pending_digits.push_back(w);
    endtask

    task automatic predict_tick(input logic b1, input logic b2, input logic b3);
        logic [9:0] limit;
        int         hr;
        int         mn;
        int         sc;
        if (b3)
            limit = period_fastest;
        else if (b2)
            limit = period_faster;
        else if (b1)
            limit = period_fast;
        else
            limit = period_normal;
        // The count wraps within its ten bits before the compare.
        tick_count = tick_count + 10'd1;
        if (tick_count >= limit)
        begin
            tick_count = '0;
            if (b1 || b2 || b3)
                step_minute();
            else
                step_second();
            hr = hour_count;
            mn = minute_count;
            sc = second_count;
            queue_digit(8'h02, 4'(hr / 10), 1'b0);
            queue_digit(8'h04, 4'(hr % 10), 1'b0);
            queue_digit(8'h08, 4'(mn / 10), 1'b0);
            queue_digit(8'h10, 4'(mn % 10), 1'b0);
            queue_digit(8'h20, 4'(sc / 10), 1'b0);
            queue_digit(8'h40, 4'(sc % 10), 1'b0);
            queue_digit(8'h01, BLANK_CODE, 1'b0);
            queue_digit(8'h80, BLANK_CODE | {3'b000, second_count[0]}, 1'b1);
        end
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_tick(input logic b1, input logic b2, input logic b3);
        int gap;
        push         <= 1'b1;
        button_one   <= b1;
        button_two   <= b2;
        button_three <= b3;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_tick(b1, b2, b3);
        if (sender_idles)
        begin
            if (burst_left == 0)
            begin
                gap        = $urandom_range(1, 12);
                burst_left = $urandom_range(1, 20);
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else
                burst_left--;
        end
    endtask

    task automatic send_random_tick();
        logic [2:0] btn;
        // At least a third of the ticks hold no button, so seconds advance too.
        if ($urandom_range(0, 2) == 0)
            btn = 3'b000;
        else
            btn = 3'($urandom_range(0, 7));
        send_tick(btn[0], btn[1], btn[2]);
    endtask

    // Wait until every predicted word has been popped, then let the block
    // finish any tick that produces no word.
    task automatic settle();
        push <= 1'b0;
        while (pending_digits.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the four periods, preceded by writes to unused indexes.
    task automatic program_periods(input logic [9:0] nrm, input logic [9:0] fst,
                                   input logic [9:0] fstr, input logic [9:0] fstst,
                                   input int unused_writes);
        logic [hms_pkg::CFG_IDX_W-1:0] idx[8];
        logic [hms_pkg::PERIOD_W-1:0]  val[8];
        int                            n;
        int                            k;
        n = 0;
        for (k = 0; k < unused_writes; k++)
        begin
            idx[n] = hms_pkg::REG_PERIOD_FASTEST + 3'(k + 1);
            val[n] = 10'($urandom_range(0, 1023));
            n++;
        end
        idx[n] = hms_pkg::REG_PERIOD_NORMAL;  val[n] = nrm;   n++;
        idx[n] = hms_pkg::REG_PERIOD_FAST;    val[n] = fst;   n++;
        idx[n] = hms_pkg::REG_PERIOD_FASTER;  val[n] = fstr;  n++;
        idx[n] = hms_pkg::REG_PERIOD_FASTEST; val[n] = fstst; n++;
        for (k = 0; k < n; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            case (idx[k])
                hms_pkg::REG_PERIOD_NORMAL:  period_normal  = val[k];
                hms_pkg::REG_PERIOD_FAST:    period_fast    = val[k];
                hms_pkg::REG_PERIOD_FASTER:  period_faster  = val[k];
                hms_pkg::REG_PERIOD_FASTEST: period_fastest = val[k];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver: its own stall pattern plus an occasional long hold-off.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        if (hold_seen != hold_requests)
        begin
            hold_seen  = hold_requests;
            stall_left = HOLD_OFF_CYCLES;
        end
        if (mode_left == 0)
        begin
            pop_mode  = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 200);
        end
        else
            mode_left--;
        if (stall_left > 0)
            pop <= 1'b0;
        else if (pop_mode == 0)
            pop <= 1'b1;
        else if (pop_mode == 1)
            pop <= ($urandom_range(0, 1) == 1);
        else
            pop <= ($urandom_range(0, 3) == 0);
    end

    // Every popped word is compared with the oldest prediction.
    always @(posedge clk)
    begin
        scan_word_t w;
        if (rst_n && pop && !empty)
        begin
            if (pending_digits.size() == 0)
            begin
                $error("unexpected digit word: strobe %0h code %0h last %0b",
                       digit_strobe, digit_code, last_digit);
                mismatches++;
            end
            else
            begin
                w = pending_digits.pop_front();
                if (digit_strobe !== w.strobe)
                begin
                    $error("digit_strobe: expected %0h, got %0h", w.strobe, digit_strobe);
                    mismatches++;
                end
                if (digit_code !== w.code)
                begin
                    $error("digit_code: expected %0h, got %0h", w.code, digit_code);
                    mismatches++;
                end
                if (last_digit !== w.last)
                begin
                    $error("last_digit: expected %0b, got %0b", w.last, last_digit);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_default_periods();
        int k;
        sender_idles = 1'b1;
        for (k = 0; k < 3; k++)
            send_tick(1'b0, 1'b0, 1'b1);
        for (k = 0; k < 10; k++)
            send_tick(1'b0, 1'b1, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b1);
        send_tick(1'b1, 1'b1, 1'b1);
        settle();
    endtask

    // Zero and full-scale periods; a short period after a long count
    // clears the prescaler on the next tick.
    task automatic test_period_extremes();
        int k;
        program_periods(10'd0, 10'd1023, 10'd2, 10'd1, 4);
        for (k = 0; k < 3; k++)
            send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b0, 1'b1, 1'b0);
        send_tick(1'b0, 1'b1, 1'b0);
        send_tick(1'b1, 1'b1, 1'b0);
        settle();
    endtask

    task automatic test_random_ticks();
        int phase;
        int k;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            sender_idles = (phase != 0) && (phase != 4);
            case (phase)
                0, 1: program_periods(10'($urandom_range(0, 6)), 10'($urandom_range(0, 6)),
                                      10'($urandom_range(0, 6)), 10'($urandom_range(0, 6)),
                                      $urandom_range(1, 4));
                2: program_periods(10'd0, 10'd1023, 10'd1, 10'd1023, $urandom_range(1, 4));
                3: program_periods(10'($urandom_range(2, 12)), 10'($urandom_range(0, 3)),
                                   10'($urandom_range(0, 3)), 10'($urandom_range(0, 3)),
                                   $urandom_range(1, 4));
                default: program_periods(10'd1, 10'd0, 10'd0, 10'd2, $urandom_range(1, 4));
            endcase
            for (k = 0; k < TICKS_PER_PHASE; k++)
                send_random_tick();
            settle();
        end
    endtask

    // The receiver holds off while every tick steps the clock, so the
    // snapshot queue fills and full must hold the sender back.
    task automatic test_backpressure();
        int k;
        sender_idles = 1'b0;
        program_periods(10'd0, 10'd0, 10'd0, 10'd0, 1);
        hold_requests <= hold_requests + 1;
        for (k = 0; k < 16; k++)
            send_random_tick();
        settle();
    endtask

    // A long normal period: one step after fifty quiet ticks, then a
    // partial count that must not step.
    task automatic test_long_period();
        int k;
        sender_idles = 1'b0;
        program_periods(10'd50, 10'd1023, 10'd1023, 10'd1023, 2);
        for (k = 0; k < 60; k++)
            send_tick(1'b0, 1'b0, 1'b0);
        settle();
    endtask

    // Carry the seconds into the minutes, then walk the minutes across
    // the next hour boundary so the carry reaches the hours.
    task automatic test_carry_chain();
        int         steps;
        int         k;
        logic [2:0] btn;
        sender_idles = 1'b0;
        program_periods(10'd0, 10'd0, 10'd0, 10'd0, 0);
        steps = 60 - int'(second_count);
        for (k = 0; k < steps; k++)
            send_tick(1'b0, 1'b0, 1'b0);
        steps = 60 - int'(minute_count);
        for (k = 0; k < steps; k++)
        begin
            btn = 3'($urandom_range(1, 7));
            send_tick(btn[0], btn[1], btn[2]);
        end
        settle();
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        push          <= 1'b0;
        button_one    <= 1'b0;
        button_two    <= 1'b0;
        button_three  <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        hold_requests <= 0;
        reset_clock_model();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_default_periods();
        test_period_extremes();
        test_random_ticks();
        test_backpressure();
        test_long_period();
        test_carry_chain();

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
